@@ hdl/tcwq_pkg.sv @@
// Package for the touch contact window qualifier.
// Holds the shared widths, register indexes and the types passed between modules.
// No dependencies.
package tcwq_pkg;

  localparam int WINDOW_SLOTS_DEF = 85;
  localparam int COUNT_W          = 7;
  localparam int HOLD_W           = 8;
  localparam int CFG_DATA_W       = 8;
  localparam int CFG_INDEX_W      = 1;

  localparam logic [COUNT_W-1:0] ON_THRESHOLD_RST = 7'd1;
  localparam logic [HOLD_W-1:0]  RELEASE_HOLD_RST = 8'd15;
  localparam logic [HOLD_W-1:0]  ELAPSED_MAX      = 8'd255;

  localparam logic [CFG_INDEX_W-1:0] CFG_ON_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_HOLD = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] on_threshold;
    logic [HOLD_W-1:0]  release_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic               upd;
    logic [COUNT_W-1:0] sum;
  } step_t;

endpackage

@@ hdl/tcwq_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read data updates only on a read enable. No dependencies.
module tcwq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/tcwq_window.sv @@
// Slot ring and running window sum for the touch contact qualifier.
// Depends on tcwq_pkg and tcwq_ram; reads the ring on accept and writes it back as the beat advances.
module tcwq_window #(
  parameter int WINDOW_SLOTS = tcwq_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  in_bit,
  input  logic                  adv,
  output tcwq_pkg::step_t       step
);

  localparam int POS_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_SLOTS - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             lapped_r, lapped_nxt;
  logic             s1_bit_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             s1_lapped_r;
  logic             s1_fwd_r;
  logic             s1_fwd_bit_r;
  logic [tcwq_pkg::COUNT_W-1:0] sum_r, sum_nxt;
  logic             rd_bit;
  logic             old_bit;
  logic             fwd_hit;

  tcwq_ram #(
    .WIDTH(1),
    .DEPTH(WINDOW_SLOTS)
  ) u_ring (
    .clk    (clk),
    .wr_en  (adv),
    .wr_addr(s1_pos_r),
    .wr_data(s1_bit_r),
    .rd_en  (accept),
    .rd_addr(pos_r),
    .rd_data(rd_bit)
  );

  // A read of the entry being written in the same cycle takes the written bit.
  assign fwd_hit = adv && (s1_pos_r == pos_r);

  always_comb begin
    pos_nxt    = pos_r;
    lapped_nxt = lapped_r;
    if (accept) begin
      if (pos_r >= POS_LAST) begin
        pos_nxt    = '0;
        lapped_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  assign old_bit = s1_fwd_r ? s1_fwd_bit_r : (s1_lapped_r & rd_bit);
  assign sum_nxt = sum_r + tcwq_pkg::COUNT_W'(s1_bit_r) - tcwq_pkg::COUNT_W'(old_bit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      lapped_r <= 1'b0;
      sum_r    <= '0;
    end else begin
      pos_r    <= pos_nxt;
      lapped_r <= lapped_nxt;
      if (adv) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bit_r     <= in_bit;
      s1_pos_r     <= pos_r;
      s1_lapped_r  <= lapped_r;
      s1_fwd_r     <= fwd_hit;
      s1_fwd_bit_r <= s1_bit_r;
    end
  end

  assign step.upd = adv;
  assign step.sum = sum_nxt;

endmodule

@@ hdl/tcwq_judge.sv @@
// Contact decision and release timer for the touch contact qualifier.
// Depends on tcwq_pkg; updates once per window step.
module tcwq_judge (
  input  logic            clk,
  input  logic            rst_n,
  input  tcwq_pkg::cfg_t  cfg,
  input  tcwq_pkg::step_t step,
  output logic            contact_nxt
);

  logic                        contact_r;
  logic                        timing_r, timing_nxt;
  logic [tcwq_pkg::HOLD_W-1:0] elapsed_r, elapsed_nxt;
  logic [tcwq_pkg::HOLD_W-1:0] elapsed_inc;

  assign elapsed_inc = (elapsed_r == tcwq_pkg::ELAPSED_MAX) ? elapsed_r
                                                             : elapsed_r + 8'd1;

  always_comb begin
    contact_nxt = contact_r;
    timing_nxt  = timing_r;
    elapsed_nxt = elapsed_r;
    if (step.upd) begin
      if (!contact_r) begin
        if (step.sum >= cfg.on_threshold) begin
          contact_nxt = 1'b1;
          timing_nxt  = 1'b0;
          elapsed_nxt = '0;
        end
      end else if (step.sum != '0) begin
        timing_nxt  = 1'b0;
        elapsed_nxt = '0;
      end else if (!timing_r) begin
        timing_nxt  = 1'b1;
        elapsed_nxt = '0;
      end else if (elapsed_inc >= cfg.release_hold_ticks) begin
        contact_nxt = 1'b0;
        timing_nxt  = 1'b0;
        elapsed_nxt = '0;
      end else begin
        elapsed_nxt = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contact_r <= 1'b0;
      timing_r  <= 1'b0;
      elapsed_r <= '0;
    end else begin
      contact_r <= contact_nxt;
      timing_r  <= timing_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

@@ hdl/touch_contact_window_qualifier_core.sv @@
// Touch contact qualifier: one beat per slot tick in, one result beat out per tick. The block
// sustains one beat per cycle while the output is not stalled: the ring entry is read on accept
// and the sum, contact decision and ring write-back happen as that beat advances, so the ring
// RAM read and write ports set the rate. Results are held in an output register while stalled,
// and one further beat is taken meanwhile. No clearing pass is needed after reset.
module touch_contact_window_qualifier_core #(
  parameter int WINDOW_SLOTS = tcwq_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_edge_seen,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_contact_active,
  output logic [tcwq_pkg::COUNT_W-1:0]        out_window_count,
  input  logic                                cfg_we,
  input  logic [tcwq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tcwq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tcwq_pkg::cfg_t  cfg_r;
  tcwq_pkg::step_t step;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            out_contact_r;
  logic [tcwq_pkg::COUNT_W-1:0] out_count_r;
  logic            accept;
  logic            adv;
  logic            contact_nxt;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_threshold       <= tcwq_pkg::ON_THRESHOLD_RST;
      cfg_r.release_hold_ticks <= tcwq_pkg::RELEASE_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tcwq_pkg::CFG_ON_THRESHOLD: begin
          cfg_r.on_threshold <= cfg_data[tcwq_pkg::COUNT_W-1:0];
        end
        tcwq_pkg::CFG_RELEASE_HOLD: begin
          cfg_r.release_hold_ticks <= cfg_data[tcwq_pkg::HOLD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  tcwq_window #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .in_bit(in_edge_seen),
    .adv   (adv),
    .step  (step)
  );

  tcwq_judge u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step       (step),
    .contact_nxt(contact_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_contact_r <= contact_nxt;
      out_count_r   <= step.sum;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_contact_active = out_contact_r;
  assign out_window_count   = out_count_r;

endmodule

@@ hdl/tcwq_checker.sv @@
// Port-level checker for the touch contact qualifier, bound to the top level.
// Depends on tcwq_pkg and touch_contact_window_qualifier_core.
module tcwq_checker #(
  parameter int WINDOW_SLOTS = tcwq_pkg::WINDOW_SLOTS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_contact_active,
  input logic [tcwq_pkg::COUNT_W-1:0] out_window_count
);

  localparam logic [tcwq_pkg::COUNT_W-1:0] COUNT_MAX = tcwq_pkg::COUNT_W'(WINDOW_SLOTS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_contact_active)
                               && $stable(out_window_count))
    else $error("Stalled result beat changed or dropped.");

  a_no_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("Input stalled while the result side is free.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_window_count <= COUNT_MAX)
    else $error("Window count exceeds the window size.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("Accepted beat did not produce a result beat in time.");

endmodule

bind touch_contact_window_qualifier_core tcwq_checker #(
  .WINDOW_SLOTS(WINDOW_SLOTS)
) u_tcwq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_contact_active(out_contact_active),
  .out_window_count  (out_window_count)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for touch_contact_window_qualifier_core: drives slot ticks and register writes,
// predicts contact state and window count per tick, and checks every result beat.
// Depends on tcwq_pkg and the core module only.
module tb;
  import tcwq_pkg::*;

  localparam int SLOTS = WINDOW_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic               active;
    logic [COUNT_W-1:0] count;
  } contact_res_t;

  class contact_scoreboard;
    bit                 slot_bits[SLOTS];
    int                 slot_pos;
    bit [COUNT_W-1:0]   edge_sum;
    bit                 active;
    bit                 timing;
    bit [HOLD_W-1:0]    elapsed;
    bit [COUNT_W-1:0]   threshold;
    bit [HOLD_W-1:0]    hold_ticks;
    contact_res_t       pending_contacts[$];
    int                 errors;

    function new();
      foreach (slot_bits[i]) slot_bits[i] = 1'b0;
      slot_pos   = 0;
      edge_sum   = '0;
      active     = 1'b0;
      timing     = 1'b0;
      elapsed    = '0;
      threshold  = ON_THRESHOLD_RST;
      hold_ticks = RELEASE_HOLD_RST;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ON_THRESHOLD) begin
        threshold = data[COUNT_W-1:0];
      end else begin
        hold_ticks = data[HOLD_W-1:0];
      end
    endfunction

    function void judge_contact();
      if (!active) begin
        if (edge_sum >= threshold) begin
          active  = 1'b1;
          timing  = 1'b0;
          elapsed = '0;
        end
      end else if (edge_sum != 0) begin
        timing  = 1'b0;
        elapsed = '0;
      end else if (!timing) begin
        timing  = 1'b1;
        elapsed = '0;
      end else begin
        if (elapsed < ELAPSED_MAX) elapsed = elapsed + 1'b1;
        if (elapsed >= hold_ticks) begin
          active  = 1'b0;
          timing  = 1'b0;
          elapsed = '0;
        end
      end
    endfunction

    function void note_slot(bit edge_bit);
      contact_res_t res;
      if (slot_pos >= SLOTS) slot_pos = 0;
      edge_sum = edge_sum + edge_bit - slot_bits[slot_pos];
      slot_bits[slot_pos] = edge_bit;
      slot_pos++;
      if (slot_pos >= SLOTS) slot_pos = 0;
      judge_contact();
      res.active = active;
      res.count  = edge_sum;
      pending_contacts.push_back(res);
    endfunction

    task report(string msg);
      if (errors < 40) $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic act, logic [COUNT_W-1:0] cnt);
      contact_res_t exp_res;
      if (pending_contacts.size() == 0) begin
        report("result beat with no tick waiting");
        return;
      end
      exp_res = pending_contacts.pop_front();
      if (act !== exp_res.active)
        report($sformatf("contact_active got %b expected %b", act, exp_res.active));
      if (cnt !== exp_res.count)
        report($sformatf("window_count got %0d expected %0d", cnt, exp_res.count));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_edge_seen = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_contact_active;
  logic [COUNT_W-1:0]     out_window_count;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_ON_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  contact_scoreboard sb = new();
  int cycle_count = 0;
  int slots_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  touch_contact_window_qualifier_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_edge_seen       (in_edge_seen),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_contact_active (out_contact_active),
    .out_window_count   (out_window_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_slot(in_edge_seen);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_contact_active, out_window_count);
  end

  task send_slot(input logic edge_bit);
    if (slots_sent < 800) begin
      send_idle_pct  = 15;
      recv_stall_pct = 61;
    end else if (slots_sent < 1600) begin
      send_idle_pct  = 61;
      recv_stall_pct = 15;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_edge_seen <= edge_bit;
    do @(posedge clk); while (in_stall);
    slots_sent++;
  endtask

  task drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_contacts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_regs(input logic [CFG_DATA_W-1:0] thr_data, input logic [CFG_DATA_W-1:0] hold_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ON_THRESHOLD;
    cfg_data  <= thr_data;
    @(posedge clk);
    sb.write_reg(CFG_ON_THRESHOLD, thr_data);
    cfg_index <= CFG_RELEASE_HOLD;
    cfg_data  <= hold_data;
    @(posedge clk);
    sb.write_reg(CFG_RELEASE_HOLD, hold_data);
    cfg_we <= 1'b0;
  endtask

  // Bursts of edges followed by a quiet run that is often long enough to empty the window
  // and to run out the release hold, mixed with stretches of random noise.
  task run_phase(input logic [CFG_DATA_W-1:0] thr_data, input logic [CFG_DATA_W-1:0] hold_data,
                 input int num_slots);
    int sent;
    int burst_len;
    int density;
    int quiet_len;
    sent = 0;
    drain_block();
    write_regs(thr_data, hold_data);
    while (sent < num_slots) begin
      if ($urandom_range(0, 9) < 7) begin
        burst_len = $urandom_range(1, 130);
        density   = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(5, 100);
        quiet_len = $urandom_range(60, SLOTS + int'(hold_data) + 60);
        repeat (burst_len) send_slot($urandom_range(1, 100) <= density);
        repeat (quiet_len) send_slot(1'b0);
        sent += burst_len + quiet_len;
      end else begin
        burst_len = $urandom_range(1, 60);
        repeat (burst_len) send_slot(1'($urandom_range(0, 1)));
        sent += burst_len;
      end
    end
  endtask

  initial begin
    logic directed_bits[10] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A zero threshold activates on an empty window, and a zero hold releases
    // on the second zero-count tick.
    write_regs(8'd0, 8'd0);
    foreach (directed_bits[i]) send_slot(directed_bits[i]);

    run_phase(8'd1, 8'd15, 250);
    run_phase(8'd85, 8'd255, 450);
    run_phase(8'hFF, 8'd0, 150);
    run_phase(8'($urandom_range(1, 30)), 8'($urandom_range(0, 40)), 300);
    run_phase(8'd86, 8'd1, 100);
    run_phase(8'($urandom_range(2, 12)), 8'($urandom_range(0, 255)), 200);

    drain_block();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_contacts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (sb.pending_contacts.size() != 0)
        sb.report($sformatf("%0d results never arrived", sb.pending_contacts.size()));
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
